// ===== rtl/psdb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psdb_pkg
// Shared types and constants for the point splat depth buffer: command and
// status codes, register indexes, controller states and the control/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package psdb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_FRAC_BITS  = 4;

  localparam int COORD_W = 16;
  localparam int DEPTH_W = 15;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 10;
  localparam int STAT_W  = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SPLAT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_HIDDEN  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd2;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ROUND  = 6'b000010,
    ST_ADDR   = 6'b000100,
    ST_READ   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic round;
    logic addr;
    logic read;
    logic update;
    logic clr_step;
    logic emit_none;
    logic emit_out;
  } ctl_t;

  typedef struct packed {
    logic in_image;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/point_splat_depth_buffer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_splat_depth_buffer_core
// Per-pixel depth buffer fed with fixed-point 3D points: clear, splat with
// strict greater-than depth test, and pixel depth read.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// status and depth for one cycle with done high and cannot be held off.
// Splat and read requests give done after round, address, registered memory
// read and depth test; a point outside the image gives done after round and
// the bounds check, an unused command in the cycle after acceptance. A clear
// sweeps the memory one entry a cycle, MAX_WIDTH*MAX_HEIGHT entries in all
// (524288 at the defaults), then gives done. After reset the same sweep runs
// with busy high and no done; the register port works throughout.
module point_splat_depth_buffer_core #(
  parameter int MAX_WIDTH  = psdb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = psdb_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = psdb_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           command,
  input  wire logic signed [psdb_pkg::COORD_W-1:0]  point_x,
  input  wire logic signed [psdb_pkg::COORD_W-1:0]  point_y,
  input  wire logic signed [psdb_pkg::COORD_W-1:0]  point_z,
  output logic                                      done,
  output logic [psdb_pkg::STAT_W-1:0]               status,
  output logic [psdb_pkg::DEPTH_W-1:0]              depth,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [2:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);
  import psdb_pkg::*;

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic               cfg_wr;
  ctl_t               ctl;
  sts_t               sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_W'(640);
      image_height <= IMG_H_W'(480);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IDX_WIDTH:  image_width  <= pwdata[IMG_W_W-1:0];
        REG_IDX_HEIGHT: image_height <= pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_WIDTH:  prdata = 32'(image_width);
      REG_IDX_HEIGHT: prdata = 32'(image_height);
      default:        prdata = '0;
    endcase
  end

  psdb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  psdb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .command      (command),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .image_width  (image_width),
    .image_height (image_height),
    .done         (done),
    .status       (status),
    .depth        (depth)
  );

endmodule
`default_nettype wire

// ===== rtl/psdb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psdb_ctrl
// Controller state machine: sequences rounding, address build, memory read
// and depth test for each request, and the clear sweep of the depth memory.
// ----------------------------------------------------------------------------
module psdb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     command,
  input  wire psdb_pkg::sts_t sts,
  output psdb_pkg::ctl_t      ctl,
  output logic                busy
);
  import psdb_pkg::*;

  state_t state;
  state_t state_next;
  logic   init_pass;
  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command) inside
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_SPLAT, CMD_READ: begin
              ctl.load   = 1'b1;
              state_next = ST_ROUND;
            end
            default: ctl.emit_none = 1'b1;
          endcase
        end
      end
      ST_ROUND: begin
        ctl.round  = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        if (sts.in_image) begin
          ctl.addr   = 1'b1;
          state_next = ST_READ;
        end else begin
          ctl.emit_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_READ: begin
        ctl.read   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          ctl.emit_none = !init_pass;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init_pass <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR && sts.clr_last) begin
        init_pass <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command == CMD_SPLAT || command == CMD_READ ||
    command == CMD_CLEAR) |=> busy)
    else $error("work request did not make the block busy");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> busy)
    else $error("no clearing pass after reset");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR && sts.clr_last |=> !busy)
    else $error("clear sweep did not end at last entry");
`endif

endmodule
`default_nettype wire

// ===== rtl/psdb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psdb_datapath
// Datapath: request registers, coordinate rounding and bounds check, pixel
// address build, depth memory with clear sweep counter, depth test and
// result registers.
// ----------------------------------------------------------------------------
module psdb_datapath #(
  parameter int MAX_WIDTH  = psdb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = psdb_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = psdb_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire psdb_pkg::ctl_t                       ctl,
  output psdb_pkg::sts_t                            sts,
  input  wire logic [1:0]                           command,
  input  wire logic signed [psdb_pkg::COORD_W-1:0]  point_x,
  input  wire logic signed [psdb_pkg::COORD_W-1:0]  point_y,
  input  wire logic signed [psdb_pkg::COORD_W-1:0]  point_z,
  input  wire logic [psdb_pkg::IMG_W_W-1:0]         image_width,
  input  wire logic [psdb_pkg::IMG_H_W-1:0]         image_height,
  output logic                                      done,
  output logic [psdb_pkg::STAT_W-1:0]               status,
  output logic [psdb_pkg::DEPTH_W-1:0]              depth
);
  import psdb_pkg::*;

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int MW = COORD_W + 1;
  localparam logic [MW-1:0] HALF      = MW'((1 << FRAC_BITS) >> 1);
  localparam logic [MW-1:0] MAXW_EXT  = MW'(MAX_WIDTH);
  localparam logic [MW-1:0] MAXH_EXT  = MW'(MAX_HEIGHT);
  localparam logic [AW-1:0] STRIDE    = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);

  logic [1:0]                cmd_q;
  logic signed [COORD_W-1:0] x_q;
  logic signed [COORD_W-1:0] y_q;
  logic signed [COORD_W-1:0] z_q;

  logic [MW-1:0] mag_x;
  logic [MW-1:0] mag_y;
  logic [MW-1:0] rx;
  logic [MW-1:0] ry;
  logic [MW-1:0] w_ext;
  logic [MW-1:0] h_ext;
  logic [MW-1:0] w_eff;
  logic [MW-1:0] h_eff;
  logic          in_x;
  logic          in_y;

  logic [XW-1:0] rx_q;
  logic [YW-1:0] ry_q;
  logic          inside_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] clr_addr;

  logic [DEPTH_W-1:0] mem [STORE_SIZE];
  logic [DEPTH_W-1:0] rd_depth;
  logic               greater;
  logic               upd_wr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [DEPTH_W-1:0] mem_wdata;

  // rounding to nearest pixel, halves away from zero, and image bounds check
  always_comb begin
    mag_x = x_q[COORD_W-1] ? (MW'(0) - MW'(x_q)) : MW'(x_q);
    mag_y = y_q[COORD_W-1] ? (MW'(0) - MW'(y_q)) : MW'(y_q);
    rx    = (mag_x + HALF) >> FRAC_BITS;
    ry    = (mag_y + HALF) >> FRAC_BITS;
    w_ext = MW'(image_width);
    h_ext = MW'(image_height);
    w_eff = (w_ext < MAXW_EXT) ? w_ext : MAXW_EXT;
    h_eff = (h_ext < MAXH_EXT) ? h_ext : MAXH_EXT;
    in_x  = (!x_q[COORD_W-1] || rx == '0) && (rx < w_eff);
    in_y  = (!y_q[COORD_W-1] || ry == '0) && (ry < h_eff);
  end

  assign greater  = $signed(z_q) > $signed({1'b0, rd_depth});
  assign upd_wr   = ctl.update && (cmd_q == CMD_SPLAT) && greater;
  assign mem_we   = ctl.clr_step || upd_wr;
  assign mem_waddr = ctl.clr_step ? clr_addr : addr_q;
  assign mem_wdata = ctl.clr_step ? '0 : z_q[DEPTH_W-1:0];

  assign sts.in_image = inside_q;
  assign sts.clr_last = (clr_addr == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= command;
      x_q   <= point_x;
      y_q   <= point_y;
      z_q   <= point_z;
    end
    if (ctl.round) begin
      rx_q     <= rx[XW-1:0];
      ry_q     <= ry[YW-1:0];
      inside_q <= in_x && in_y;
    end
    if (ctl.addr) begin
      addr_q <= (AW'(ry_q) * STRIDE) + AW'(rx_q);
    end
  end

  // depth memory, one port each for read and write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl.read) begin
      rd_depth <= mem[addr_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= sts.clr_last ? '0 : clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.update || ctl.emit_none || ctl.emit_out;
    end
    if (ctl.emit_none) begin
      status <= STAT_DONE;
      depth  <= '0;
    end else if (ctl.emit_out) begin
      status <= STAT_OUTSIDE;
      depth  <= '0;
    end else if (ctl.update) begin
      if (cmd_q == CMD_SPLAT && greater) begin
        status <= STAT_DONE;
        depth  <= z_q[DEPTH_W-1:0];
      end else begin
        status <= (cmd_q == CMD_SPLAT) ? STAT_HIDDEN : STAT_DONE;
        depth  <= rd_depth;
      end
    end
  end

`ifndef SYNTHESIS
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_OUTSIDE |-> depth == '0)
    else $error("outside result with nonzero depth");

  a_stored_nonzero: assert property (@(posedge clk) disable iff (rst)
    upd_wr |=> done && status == STAT_DONE && depth != '0)
    else $error("stored depth not reported");

  a_sweep_steps: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_step && !sts.clr_last |=> clr_addr == $past(clr_addr) + AW'(1))
    else $error("clear sweep skipped an entry");
`endif

endmodule
`default_nettype wire
